FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cttbl_pkg.sv
// Types, codes and helpers for the connection tracking table.
package cttbl_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int OUT_CNT_W = 7;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // Function selector
  localparam logic [1:0] FN_UPDATE = 2'd0;
  localparam logic [1:0] FN_QUERY  = 2'd1;
  localparam logic [1:0] FN_TICK   = 2'd2;
  localparam logic [1:0] FN_NOP    = 2'd3;

  // Flow states
  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_EST     = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // Outcomes
  localparam logic [2:0] OC_ORIG  = 3'd0;
  localparam logic [2:0] OC_REPLY = 3'd1;
  localparam logic [2:0] OC_MISS  = 3'd2;
  localparam logic [2:0] OC_FREE  = 3'd3;
  localparam logic [2:0] OC_EVICT = 3'd4;

  // Protocols
  localparam logic [7:0] P_TCP  = 8'd6;
  localparam logic [7:0] P_ICMP = 8'd1;

  // TCP flags that close a flow: FIN and RST
  localparam logic [7:0] FL_CLOSE = 8'h05;

  // Register indexes
  localparam logic [1:0] REG_TCP_EST   = 2'd0;
  localparam logic [1:0] REG_TCP_OTHER = 2'd1;
  localparam logic [1:0] REG_UDP       = 2'd2;
  localparam logic [1:0] REG_ICMP      = 2'd3;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_sec;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [7:0]  proto_num;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
  } item_t;

  // Classified request handed from the front to the engine
  typedef struct packed {
    item_t item;
    logic  scan;
  } req_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  conn_state;
    logic [31:0] seen_sec;
    logic [31:0] orig_count;
    logic [31:0] reply_count;
  } entry_t;

  typedef struct packed {
    logic [2:0]           outcome;
    logic [1:0]           flow_state;
    logic [31:0]          orig_packets;
    logic [31:0]          reply_packets;
    logic [OUT_CNT_W-1:0] active_flows;
    logic [OUT_CNT_W-1:0] expired_flows;
  } result_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] active;
  } status_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

FILE: rtl/cttbl_front.sv
// Input side: accepts words, classifies them and queues them for the engine.
module cttbl_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cttbl_pkg::item_t in_item,
  output logic             req_valid,
  input  logic             req_ready,
  output cttbl_pkg::req_t  req
);
  import cttbl_pkg::*;

  req_t               q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;
  logic               pop;
  req_t               cls;

  assign in_ready  = (count != Q_CNT_W'(Q_DEPTH));
  assign req_valid = (count != '0);
  assign req       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = req_valid && req_ready;

  // Classify: the unused selector needs no table walk
  always_comb begin
    cls.item = in_item;
    cls.scan = (in_item.func != FN_NOP);
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/cttbl_engine.sv
// Back end: walks the flow table one entry a cycle and updates it.
module cttbl_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  cttbl_pkg::req_t     req,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cttbl_pkg::result_t  out_result,
  output cttbl_pkg::status_t  status
);
  import cttbl_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  // Timeout registers
  logic [31:0] tmo_tcp_est, tmo_tcp_other, tmo_udp, tmo_icmp;

  // Table
  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] slot_valid;
  logic [CNT_W-1:0]   active;

  // Control
  logic [1:0]       state;
  req_t             cur;
  logic [IDX_W-1:0] iss_idx;
  logic             iss_on;
  logic             rd_on;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_data;
  logic             rd_vld;

  // Search trackers
  logic             o_hit, r_hit, f_hit;
  logic [IDX_W-1:0] o_idx, r_idx, f_idx, old_idx;
  entry_t           o_ent, r_ent;
  logic [31:0]      best_age;
  logic [CNT_W-1:0] exp_cnt;

  // Finish stage
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  result_t          res;
  logic             active_inc;
  logic             out_free;

  // Scan evaluation
  logic        m_orig, m_reply, expire;
  logic [31:0] age, tmo;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign status.busy   = (state != S_IDLE);
  assign status.active = active;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tmo_tcp_est   <= 32'd3600;
      tmo_tcp_other <= 32'd120;
      tmo_udp       <= 32'd30;
      tmo_icmp      <= 32'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TCP_EST:   tmo_tcp_est   <= cfg_data;
        REG_TCP_OTHER: tmo_tcp_other <= cfg_data;
        REG_UDP:       tmo_udp       <= cfg_data;
        REG_ICMP:      tmo_icmp      <= cfg_data;
        default:       tmo_udp       <= tmo_udp;
      endcase
    end
  end

  // Entry compare, age and timeout for the entry just read
  always_comb begin
    m_orig  = rd_vld && (rd_data.proto == cur.item.proto_num) &&
              (rd_data.src_addr == cur.item.source_addr) &&
              (rd_data.dst_addr == cur.item.dest_addr) &&
              (rd_data.sport == cur.item.source_port) &&
              (rd_data.dport == cur.item.dest_port);
    m_reply = rd_vld && (rd_data.proto == cur.item.proto_num) &&
              (rd_data.dst_addr == cur.item.source_addr) &&
              (rd_data.src_addr == cur.item.dest_addr) &&
              (rd_data.dport == cur.item.source_port) &&
              (rd_data.sport == cur.item.dest_port);
    age = cur.item.now_sec - rd_data.seen_sec;
    if (rd_data.proto == P_TCP) begin
      tmo = (rd_data.conn_state == ST_EST) ? tmo_tcp_est : tmo_tcp_other;
    end else if (rd_data.proto == P_ICMP) begin
      tmo = tmo_icmp;
    end else begin
      tmo = tmo_udp;
    end
    expire = rd_on && rd_vld && (cur.item.func == FN_TICK) && (age >= tmo);
  end

  // Finish: pick the slot, build the written entry and the result
  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = o_idx;
    mem_wd     = o_ent;
    active_inc = 1'b0;
    res        = '0;
    res.outcome = OC_ORIG;
    res.flow_state = ST_NEW;
    case (cur.item.func)
      FN_UPDATE: begin
        if (o_hit) begin
          mem_wd.seen_sec   = cur.item.now_sec;
          mem_wd.orig_count = sat_inc(o_ent.orig_count);
          if ((cur.item.proto_num == P_TCP) && ((cur.item.tcp_flag_bits & FL_CLOSE) != '0)) begin
            mem_wd.conn_state = ST_NEW;
          end
          res.outcome = OC_ORIG;
        end else if (r_hit) begin
          mem_wa = r_idx;
          mem_wd = r_ent;
          mem_wd.seen_sec    = cur.item.now_sec;
          mem_wd.reply_count = sat_inc(r_ent.reply_count);
          if (r_ent.conn_state == ST_NEW) begin
            mem_wd.conn_state = ST_EST;
          end
          res.outcome = OC_REPLY;
        end else begin
          mem_wa = f_hit ? f_idx : old_idx;
          mem_wd.src_addr    = cur.item.source_addr;
          mem_wd.dst_addr    = cur.item.dest_addr;
          mem_wd.proto       = cur.item.proto_num;
          mem_wd.sport       = cur.item.source_port;
          mem_wd.dport       = cur.item.dest_port;
          mem_wd.conn_state  = ST_NEW;
          mem_wd.seen_sec    = cur.item.now_sec;
          mem_wd.orig_count  = 32'd1;
          mem_wd.reply_count = 32'd0;
          active_inc  = f_hit;
          res.outcome = f_hit ? OC_FREE : OC_EVICT;
        end
        mem_we = (state == S_FINISH) && out_free;
        res.flow_state    = mem_wd.conn_state;
        res.orig_packets  = mem_wd.orig_count;
        res.reply_packets = mem_wd.reply_count;
      end
      FN_QUERY: begin
        if (o_hit) begin
          res.outcome       = OC_ORIG;
          res.flow_state    = o_ent.conn_state;
          res.orig_packets  = o_ent.orig_count;
          res.reply_packets = o_ent.reply_count;
        end else if (r_hit) begin
          res.outcome       = OC_REPLY;
          res.flow_state    = r_ent.conn_state;
          res.orig_packets  = r_ent.orig_count;
          res.reply_packets = r_ent.reply_count;
        end else begin
          res.outcome    = OC_MISS;
          res.flow_state = ST_INVALID;
        end
      end
      FN_TICK: begin
        res.expired_flows = OUT_CNT_W'(exp_cnt);
      end
      default: begin
        res.expired_flows = '0;
      end
    endcase
    res.active_flows = OUT_CNT_W'(active + CNT_W'(active_inc));
  end

  // Table memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[iss_idx];
  end

  // Sequencer, trackers and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      iss_on     <= 1'b0;
      rd_on      <= 1'b0;
      iss_idx    <= '0;
      slot_valid <= '0;
      active     <= '0;
      out_valid  <= 1'b0;
    end else begin
      // a result taken while no new one is loaded empties the output
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      rd_on  <= iss_on;
      rd_idx <= iss_idx;
      rd_vld <= slot_valid[iss_idx];
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur     <= req;
            o_hit   <= 1'b0;
            r_hit   <= 1'b0;
            f_hit   <= 1'b0;
            exp_cnt <= '0;
            iss_idx <= '0;
            iss_on  <= req.scan;
            state   <= req.scan ? S_SCAN : S_FINISH;
          end
        end
        S_SCAN: begin
          if (iss_on) begin
            iss_idx <= iss_idx + 1'b1;
            if (iss_idx == IDX_W'(ENTRIES - 1)) begin
              iss_on <= 1'b0;
            end
          end
          if (rd_on) begin
            if (m_orig && !o_hit) begin
              o_hit <= 1'b1;
              o_idx <= rd_idx;
              o_ent <= rd_data;
            end
            if (m_reply && !r_hit) begin
              r_hit <= 1'b1;
              r_idx <= rd_idx;
              r_ent <= rd_data;
            end
            if (!rd_vld && !f_hit) begin
              f_hit <= 1'b1;
              f_idx <= rd_idx;
            end
            if ((rd_idx == '0) || (age > best_age)) begin
              best_age <= age;
              old_idx  <= rd_idx;
            end
            if (expire) begin
              slot_valid[rd_idx] <= 1'b0;
              exp_cnt <= exp_cnt + 1'b1;
              if (active != '0) begin
                active <= active - 1'b1;
              end
            end
            if (rd_idx == IDX_W'(ENTRIES - 1)) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_result <= res;
            state      <= S_IDLE;
            if (mem_we) begin
              slot_valid[mem_wa] <= 1'b1;
              active <= active + CNT_W'(active_inc);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/connection_tracking_table.sv
// Top level of the connection tracking table.
//
//  channel   direction  words carried
//  s_axis    in         one update, query or tick item
//  m_axis    out        one result word per item
//  cfg       in         timeout register writes, no handshake
//
// For each item the engine reads the table memory one entry a cycle through
// its single read port, then writes back the entry of an update and loads the
// output register. The unused selector skips the walk. Reset is synchronous
// on rst and clears the valid bits at once; no clearing pass. The two-word
// queue keeps taking items while the engine walks, and a stalled result holds
// the engine only.
module connection_tracking_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [31:0] now_sec, [63:32] source_addr, [95:64] dest_addr, [103:96] proto_num,
  // [119:104] source_port, [135:120] dest_port, [143:136] tcp_flag_bits
  input  logic [143:0]  s_axis_tdata,
  // [1:0] func
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [1:0] flow_state, [33:2] orig_packets, [65:34] reply_packets,
  // [72:66] active_flows, [79:73] expired_flows
  output logic [79:0]   m_axis_tdata,
  // [2:0] outcome
  output logic [2:0]    m_axis_tuser,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import cttbl_pkg::*;

`include "assert_macros.svh"

  item_t   in_item;
  req_t    req;
  logic    req_valid;
  logic    req_ready;
  result_t res;
  status_t status;

  // Unpack the input word
  always_comb begin
    in_item.func          = s_axis_tuser;
    in_item.now_sec       = s_axis_tdata[31:0];
    in_item.source_addr   = s_axis_tdata[63:32];
    in_item.dest_addr     = s_axis_tdata[95:64];
    in_item.proto_num     = s_axis_tdata[103:96];
    in_item.source_port   = s_axis_tdata[119:104];
    in_item.dest_port     = s_axis_tdata[135:120];
    in_item.tcp_flag_bits = s_axis_tdata[143:136];
  end

  cttbl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  cttbl_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (res),
    .status     (status)
  );

  // Pack the result word
  assign m_axis_tuser = res.outcome;
  assign m_axis_tdata = {res.expired_flows, res.active_flows, res.reply_packets,
                         res.orig_packets, res.flow_state};

  // Checks
  `ASSERT_CLK(a_active_bound, clk, rst, (status.active <= CNT_W'(ENTRIES)), "active count above table size")
  `ASSERT_CLK(a_expire_tick, clk, rst, (m_axis_tvalid && (res.expired_flows != '0)) |-> (res.outcome == OC_ORIG && res.orig_packets == '0), "expired count on a non-tick result")
  `ASSERT_CLK(a_take_idle, clk, rst, (req_valid && req_ready) |=> status.busy, "engine idle after taking a request")

endmodule
